// File: rtl/mwo_pkg.sv
// mwo_pkg: shared types and constants of the mecanum wheel odometry block
// no dependencies
package mwo_pkg;

  localparam int TickW = 32;
  localparam int TimeW = 32;
  localparam int OutW  = 32;

  localparam int InDataW  = 4 * TickW + TimeW;
  localparam int OutDataW = TimeW + 3 * OutW;
  localparam int OutUserW = 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 22;

  localparam int RadiusW = 20;
  localparam int TprW    = 16;
  localparam int GearW   = 8;
  localparam int HalfW   = 22;

  localparam int SumW  = TickW + 3;     // signed wheel combination
  localparam int MagW  = TickW + 2;     // its magnitude
  localparam int GnW   = GearW + TprW + 1;
  localparam int LwW   = HalfW + 1;
  localparam int ProdW = 160;           // shift-add accumulator
  localparam int MplW  = 40;            // multiplier operand
  localparam int DenW  = 80;
  localparam int PW    = 128;           // radius times constant
  localparam int DivW  = 176;
  localparam int QW    = OutW + 1;
  localparam int DenShift = 60;
  localparam int CntW  = 6;

  localparam logic [3:0] CFG_RADIUS = 4'd0;
  localparam logic [3:0] CFG_TPR    = 4'd1;
  localparam logic [3:0] CFG_GEAR   = 4'd2;
  localparam logic [3:0] CFG_HLEN   = 4'd3;
  localparam logic [3:0] CFG_HWID   = 4'd4;

  localparam logic [63:0]      PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [ProdW-1:0] K_LIN  = ProdW'(PI_Q60) * ProdW'(1000000);
  localparam logic [ProdW-1:0] K_ANG  = ProdW'(PI_Q60) * ProdW'(64'd1000000000000);

  typedef enum logic [2:0] {
    MS_DEN, MS_RK1, MS_NX, MS_NY, MS_DENZ, MS_RK2, MS_NZ
  } mul_sel_e;

  typedef enum logic [1:0] {
    DS_X, DS_Y, DS_Z
  } div_sel_e;

  typedef struct packed {
    logic [RadiusW-1:0] radius;
    logic [TprW-1:0]    tpr;
    logic [GearW-1:0]   gear;
    logic [HalfW-1:0]   hlen;
    logic [HalfW-1:0]   hwid;
  } cfg_t;

  typedef struct packed {
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic mul_done;
    logic div_done;
    logic prime;
    logic dterr;
    logic lw_zero;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/mecanum_wheel_odometry.sv
// mecanum_wheel_odometry: four-wheel mecanum odometry, one result per sample
// a priming or zero-dt sample skips the arithmetic; any other sample waits on
// the shift-add multiplier (one operand bit per cycle) and the 33-step divider
// throughput: one sample at a time; the next is taken once the result is registered
// reset: asynchronous active low, config to defaults, first sample primes the state
// depends on mwo_pkg, mwo_ctrl, mwo_dp
module mecanum_wheel_odometry (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mwo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mwo_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tick_front_left, tick_front_right, tick_rear_left, tick_rear_right, stamp_us
  input  logic [mwo_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_stamp_us, vel_x, vel_y, yaw_rate
  output logic [mwo_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // priming, dt_error
  output logic [mwo_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import mwo_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{radius: RadiusW'(77000), tpr: TprW'(43), gear: GearW'(5),
                 hlen: HalfW'(180000), hwid: HalfW'(170000)};
    end else if (cfg_we_i) begin
      case (4'(cfg_idx_i))
        CFG_RADIUS: cfg_q.radius <= cfg_data_i[RadiusW-1:0];
        CFG_TPR:    cfg_q.tpr    <= cfg_data_i[TprW-1:0];
        CFG_GEAR:   cfg_q.gear   <= cfg_data_i[GearW-1:0];
        CFG_HLEN:   cfg_q.hlen   <= cfg_data_i[HalfW-1:0];
        CFG_HWID:   cfg_q.hwid   <= cfg_data_i[HalfW-1:0];
        default: ;
      endcase
    end
  end

  assign load = s_axis_tvalid_i && s_axis_tready_o;

  mwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready_o)
  );

  mwo_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .load_i      (load),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

// File: rtl/mwo_ctrl.sv
// mwo_ctrl: sequencer for the odometry datapath
// depends on mwo_pkg
module mwo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mwo_pkg::stat_t stat_i,
  output mwo_pkg::cmd_t  cmd_o,
  output logic          in_ready_o
);
  import mwo_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MUL, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;

  assign cmd_o      = cmd_q;
  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= '{mul_start: 1'b0, mul_sel: MS_DEN, div_start: 1'b0,
                   div_sel: DS_X, publish: 1'b0};
    end else begin
      cmd_q.mul_start <= 1'b0;
      cmd_q.div_start <= 1'b0;
      cmd_q.publish   <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (stat_i.accept) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (stat_i.prime || stat_i.dterr) begin
            state_q <= ST_OUT;
          end else begin
            state_q         <= ST_MUL;
            cmd_q.mul_start <= 1'b1;
            cmd_q.mul_sel   <= MS_DEN;
          end
        end
        ST_MUL: begin
          if (stat_i.mul_done) begin
            case (cmd_q.mul_sel)
              MS_DEN:  begin cmd_q.mul_start <= 1'b1; cmd_q.mul_sel <= MS_RK1; end
              MS_RK1:  begin cmd_q.mul_start <= 1'b1; cmd_q.mul_sel <= MS_NX; end
              MS_DENZ: begin cmd_q.mul_start <= 1'b1; cmd_q.mul_sel <= MS_RK2; end
              MS_RK2:  begin cmd_q.mul_start <= 1'b1; cmd_q.mul_sel <= MS_NZ; end
              MS_NX: begin
                state_q <= ST_DIV; cmd_q.div_start <= 1'b1; cmd_q.div_sel <= DS_X;
              end
              MS_NY: begin
                state_q <= ST_DIV; cmd_q.div_start <= 1'b1; cmd_q.div_sel <= DS_Y;
              end
              default: begin
                state_q <= ST_DIV; cmd_q.div_start <= 1'b1; cmd_q.div_sel <= DS_Z;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (stat_i.div_done) begin
            case (cmd_q.div_sel)
              DS_X: begin
                state_q <= ST_MUL; cmd_q.mul_start <= 1'b1; cmd_q.mul_sel <= MS_NY;
              end
              DS_Y: begin
                if (stat_i.lw_zero) begin
                  state_q <= ST_OUT;
                end else begin
                  state_q <= ST_MUL; cmd_q.mul_start <= 1'b1; cmd_q.mul_sel <= MS_DENZ;
                end
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_OUT: begin
          if (stat_i.out_free) begin
            cmd_q.publish <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/mwo_dp.sv
// mwo_dp: sample state, shift-add multiplier, restoring divider, result register
// depends on mwo_pkg
module mwo_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mwo_pkg::cfg_t                 cfg_i,
  input  mwo_pkg::cmd_t                 cmd_i,
  input  logic                          load_i,
  input  logic [mwo_pkg::InDataW-1:0]   in_data_i,
  input  logic                          out_ready_i,
  output mwo_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  output logic [mwo_pkg::OutDataW-1:0]  out_data_o,
  output logic [mwo_pkg::OutUserW-1:0]  out_user_o
);
  import mwo_pkg::*;

  logic [TickW-1:0] prev_q [4];
  logic [TickW-1:0] cur    [4];
  logic signed [TickW-1:0] dlt [4];
  logic [TimeW-1:0] prev_stamp_q, stamp_q, dt_q, dt_d, now;
  logic             first_q, prime_q, dterr_q;
  logic signed [SumW-1:0] sx, sy, sz;
  logic [MagW-1:0]  magx_q, magy_q, magz_q;
  logic             negx_q, negy_q, negz_q;

  logic [ProdW-1:0] acc_q, mcand_q, mcand_d;
  logic [MplW-1:0]  mpl_q, mpl_d;
  logic             mbusy_q;
  mul_sel_e         msel_q;
  logic             mul_done;

  logic [DenW-1:0]  den_q;
  logic [PW-1:0]    p_q;
  logic [ProdW-1:0] num_q;

  logic [DivW-1:0]  rem_q, ds_q;
  logic [QW-1:0]    quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             dbusy_q, dneg_q, div_done;
  div_sel_e         dsel_q;
  logic [OutW-1:0]  lim, mag, res;

  logic [OutW-1:0]  vx_q, vy_q, wz_q;
  logic             ovalid_q;

  logic [GearW-1:0] g;
  logic [TprW-1:0]  n;
  logic [GnW-1:0]   gn2;
  logic [LwW-1:0]   lw;

  assign g   = (cfg_i.gear == '0) ? GearW'(1) : cfg_i.gear;
  assign n   = (cfg_i.tpr == '0) ? TprW'(1) : cfg_i.tpr;
  assign gn2 = {GnW'(g) * GnW'(n)} << 1;
  assign lw  = LwW'(cfg_i.hlen) + LwW'(cfg_i.hwid);

  assign now  = in_data_i[4*TickW +: TimeW];
  assign dt_d = now - prev_stamp_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cur[i] = in_data_i[i*TickW +: TickW];
      dlt[i] = $signed(cur[i] - prev_q[i]);
    end
    sx =  SumW'(dlt[0]) + SumW'(dlt[1]) + SumW'(dlt[2]) + SumW'(dlt[3]);
    sy = -SumW'(dlt[0]) + SumW'(dlt[1]) + SumW'(dlt[2]) - SumW'(dlt[3]);
    sz = -SumW'(dlt[0]) + SumW'(dlt[1]) - SumW'(dlt[2]) + SumW'(dlt[3]);
  end

  // sample state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      prime_q      <= 1'b0;
      dterr_q      <= 1'b0;
      prev_stamp_q <= '0;
      for (int i = 0; i < 4; i++) prev_q[i] <= '0;
    end else if (load_i) begin
      first_q      <= 1'b0;
      prime_q      <= first_q;
      dterr_q      <= !first_q && (dt_d == '0);
      prev_stamp_q <= now;
      for (int i = 0; i < 4; i++) prev_q[i] <= cur[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stamp_q <= now;
      dt_q    <= dt_d;
      negx_q  <= sx[SumW-1];
      negy_q  <= sy[SumW-1];
      negz_q  <= sz[SumW-1];
      magx_q  <= sx[SumW-1] ? MagW'(-sx) : MagW'(sx);
      magy_q  <= sy[SumW-1] ? MagW'(-sy) : MagW'(sy);
      magz_q  <= sz[SumW-1] ? MagW'(-sz) : MagW'(sz);
    end
  end

  // shift-add multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MS_DEN:  begin mcand_d = ProdW'(gn2);   mpl_d = MplW'(dt_q); end
      MS_RK1:  begin mcand_d = K_LIN;         mpl_d = MplW'(cfg_i.radius); end
      MS_NX:   begin mcand_d = ProdW'(p_q);   mpl_d = MplW'(magx_q); end
      MS_NY:   begin mcand_d = ProdW'(p_q);   mpl_d = MplW'(magy_q); end
      MS_DENZ: begin mcand_d = ProdW'(den_q); mpl_d = MplW'(lw); end
      MS_RK2:  begin mcand_d = K_ANG;         mpl_d = MplW'(cfg_i.radius); end
      default: begin mcand_d = ProdW'(p_q);   mpl_d = MplW'(magz_q); end
    endcase
  end

  assign mul_done = mbusy_q && (mpl_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
    end else if (mul_done) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      acc_q   <= '0;
      mcand_q <= mcand_d;
      mpl_q   <= mpl_d;
      msel_q  <= cmd_i.mul_sel;
    end else if (mbusy_q && !mul_done) begin
      if (mpl_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q <= mcand_q << 1;
      mpl_q   <= mpl_q >> 1;
    end
    if (mul_done) begin
      case (msel_q)
        MS_DEN, MS_DENZ: den_q <= acc_q[DenW-1:0];
        MS_RK1, MS_RK2:  p_q   <= acc_q[PW-1:0];
        default:         num_q <= acc_q;
      endcase
    end
  end

  // restoring divider, rounded: floor((2num + den) / (2den)), den scaled by 2^60
  assign div_done = dbusy_q && (cnt_q == '0);
  assign lim      = dneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mag      = (quot_q[QW-1] || (quot_q[OutW-1:0] > lim)) ? lim : quot_q[OutW-1:0];
  assign res      = dneg_q ? (-mag) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
    end else if (div_done) begin
      dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= (DivW'(num_q) << 1) + (DivW'(den_q) << DenShift);
      ds_q   <= DivW'(den_q) << (DenShift + 1 + QW - 1);
      quot_q <= '0;
      cnt_q  <= CntW'(QW);
      dsel_q <= cmd_i.div_sel;
      case (cmd_i.div_sel)
        DS_X:    dneg_q <= negx_q;
        DS_Y:    dneg_q <= negy_q;
        default: dneg_q <= negz_q;
      endcase
    end else if (dbusy_q && !div_done) begin
      if (rem_q >= ds_q) begin
        rem_q  <= rem_q - ds_q;
        quot_q <= {quot_q[QW-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[QW-2:0], 1'b0};
      end
      ds_q  <= ds_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vx_q <= '0;
      vy_q <= '0;
      wz_q <= '0;
    end else if (div_done) begin
      case (dsel_q)
        DS_X:    vx_q <= res;
        DS_Y:    vy_q <= res;
        default: wz_q <= res;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_data_o <= {wz_q, vy_q, vx_q, stamp_q};
      out_user_o <= {dterr_q, prime_q};
    end
  end

  assign out_valid_o = ovalid_q;

  assign stat_o = '{accept: load_i, mul_done: mul_done, div_done: div_done,
                    prime: prime_q, dterr: dterr_q, lw_zero: (lw == '0),
                    out_free: (!ovalid_q || out_ready_i)};

endmodule

// File: rtl/mwo_checker.sv
// mwo_checker: port-level checks of the odometry block, bound to the top level
// depends on mwo_pkg and mecanum_wheel_odometry
module mwo_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [mwo_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [mwo_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import mwo_pkg::*;

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("priming and dt error together");

  a_prime_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[OutDataW-1:TimeW] == '0)
    else $error("priming result with velocity");

  a_dt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o[OutDataW-1:TimeW] == '0)
    else $error("dt error result with velocity");

endmodule

bind mecanum_wheel_odometry mwo_checker u_mwo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: sim/mecanum_wheel_odometry_tb.sv
// testbench of mecanum_wheel_odometry: streams wheel tick samples through the block
// and checks every result against a bit-exact predictor, across several parameter sets
// depends on mwo_pkg and the mecanum_wheel_odometry rtl
module mecanum_wheel_odometry_tb;
  import mwo_pkg::*;

  typedef struct {
    logic [31:0] stamp;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wz;
    logic        prime;
    logic        dterr;
  } motion_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic [OutUserW-1:0]  m_axis_tuser_o;

  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  mecanum_wheel_odometry dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  class odo_scoreboard;
    logic [19:0] radius = 20'd77000;
    logic [15:0] tpr = 16'd43;
    logic [7:0]  gear = 8'd5;
    logic [21:0] hlen = 22'd180000;
    logic [21:0] hwid = 22'd170000;
    logic [31:0] prev_tick [4];
    logic [31:0] prev_stamp = '0;
    bit          first = 1'b1;
    motion_t     expected_q [$];

    function new();
      foreach (prev_tick[i]) prev_tick[i] = '0;
    endfunction

    function void set_reg(input logic [3:0] idx, input logic [21:0] v);
      case (idx)
        CFG_RADIUS: radius = v[19:0];
        CFG_TPR:    tpr = v[15:0];
        CFG_GEAR:   gear = v[7:0];
        CFG_HLEN:   hlen = v;
        CFG_HWID:   hwid = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] round_sat(input logic signed [35:0] s, input logic [255:0] k,
                                    input logic [255:0] den);
      logic [255:0] num, q, lim;
      bit neg;
      neg = s < 0;
      num = (neg ? 256'(-s) : 256'(s)) * k;
      if (num == 0) return '0;
      q = (2 * num + den) / (2 * den);
      lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      if (q > lim) q = lim;
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function motion_t predict_motion(input logic [InDataW-1:0] d);
      motion_t m;
      logic signed [35:0] dw [4];
      logic signed [35:0] sx, sy, sz;
      logic [31:0] dtv;
      logic [255:0] base, den, lw;
      logic [31:0] g, n;
      m.stamp = d[159:128];
      dtv = m.stamp - prev_stamp;
      m.prime = first;
      m.dterr = !first && dtv == 0;
      m.vx = '0; m.vy = '0; m.wz = '0;
      if (!first && dtv != 0) begin
        for (int i = 0; i < 4; i++) dw[i] = 36'(signed'(d[32*i +: 32] - prev_tick[i]));
        sx = dw[0] + dw[1] + dw[2] + dw[3];
        sy = -dw[0] + dw[1] + dw[2] - dw[3];
        sz = -dw[0] + dw[1] - dw[2] + dw[3];
        g = (gear == 0) ? 32'd1 : 32'(gear);
        n = (tpr == 0) ? 32'd1 : 32'(tpr);
        base = 256'(radius) * 256'(PI_Q60);
        den = (256'(2) * g * n * dtv) << 60;
        m.vx = round_sat(sx, base * 256'(1000000), den);
        m.vy = round_sat(sy, base * 256'(1000000), den);
        lw = 256'(hlen) + 256'(hwid);
        if (lw != 0) m.wz = round_sat(sz, base * 256'(64'd1000000000000), den * lw);
      end
      for (int i = 0; i < 4; i++) prev_tick[i] = d[32*i +: 32];
      prev_stamp = m.stamp;
      first = 1'b0;
      return m;
    endfunction

    function void note_sample(input logic [InDataW-1:0] d);
      expected_q.push_back(predict_motion(d));
    endfunction

    task check_result(input logic [OutDataW-1:0] d, input logic [OutUserW-1:0] u);
      motion_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      e = expected_q.pop_front();
      if (d[31:0] !== e.stamp) report($sformatf("stamp %h exp %h", d[31:0], e.stamp));
      if (d[63:32] !== e.vx) report($sformatf("vel_x %h exp %h", d[63:32], e.vx));
      if (d[95:64] !== e.vy) report($sformatf("vel_y %h exp %h", d[95:64], e.vy));
      if (d[127:96] !== e.wz) report($sformatf("yaw_rate %h exp %h", d[127:96], e.wz));
      if (u[0] !== e.prime) report($sformatf("priming %b exp %b", u[0], e.prime));
      if (u[1] !== e.dterr) report($sformatf("dt_error %b exp %b", u[1], e.dterr));
    endtask
  endclass

  odo_scoreboard sb = new();
  logic [31:0] last_tick [4] = '{default: '0};
  logic [31:0] last_stamp = '0;

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [3:0] idx, input logic [21:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[CfgIdxW-1:0];
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic load_params(input logic [21:0] r, n, g, l, w);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_TPR, n);
    write_reg(CFG_GEAR, g);
    write_reg(CFG_HLEN, l);
    write_reg(CFG_HWID, w);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [31:0] fl, fr, rl, rr, st);
    logic [InDataW-1:0] d;
    d = {st, rr, rl, fr, fl};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(d);
    last_tick = '{fl, fr, rl, rr};
    last_stamp = st;
  endtask

  task automatic send_random();
    int unsigned r;
    logic [31:0] t [4];
    logic [31:0] st;
    r = $urandom_range(99);
    for (int i = 0; i < 4; i++) begin
      if (r < 8 || $urandom_range(19) == 0) t[i] = $urandom();
      else t[i] = last_tick[i] + $urandom_range(4000) - 2000;
    end
    if (r < 8) st = $urandom();
    else if (r < 14) st = last_stamp;
    else if (r < 20) st = last_stamp + $urandom_range(1, 3);
    else if (r < 24) st = last_stamp + $urandom();
    else st = last_stamp + $urandom_range(1, 20000);
    send_sample(t[0], t[1], t[2], t[3], st);
  endtask

  initial begin
    logic [21:0] cfg_set [6][5];
    cfg_set = '{
      '{22'd77000, 22'd43, 22'd5, 22'd180000, 22'd170000},
      '{22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF},
      '{22'd1, 22'd1, 22'd1, 22'd0, 22'd0},
      '{22'd500, 22'd0, 22'd0, 22'd1, 22'd0},
      '{22'd50000, 22'd1024, 22'd20, 22'd250000, 22'd200000},
      '{22'(1 + $urandom_range(999999)), 22'($urandom_range(1, 65535)),
        22'($urandom_range(1, 255)), 22'($urandom_range(4000000)), 22'($urandom_range(4000000))}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 26 : (p < 4) ? 51 : 0;
      recv_stall_pct = (p < 2) ? 51 : (p < 4) ? 26 : 0;
      load_params(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2], cfg_set[p][3], cfg_set[p][4]);
      if (p == 0) begin
        // priming, zero dt, wraps and saturation
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_sample(32'h8000_0001, 32'h7FFF_FFF0, 32'h5, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0000_0010);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0000_0011);
        send_sample(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0012);
        send_sample(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(32'h0000_0064, 32'h0000_0064, 32'h8000_0064, 32'h8000_0064, 32'h7FFF_FFFF);
        send_sample(32'h0000_0065, 32'h0000_0063, 32'h8000_0063, 32'h8000_0065, 32'h8000_0000);
        send_sample(32'h0000_0065, 32'h0000_0063, 32'h8000_0063, 32'h8000_0065, 32'h8000_4E20);
        send_sample(32'h0000_03E8, 32'hFFFF_FC18, 32'h8000_03E8, 32'h8000_0000, 32'h8000_4E21);
      end
      repeat (105) send_random();
      s_axis_tvalid_i <= 1'b0;
      drain();
    end
    if (sb.expected_q.size() != 0) report("results missing at end of run");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/mwo_pkg.sv
rtl/mwo_ctrl.sv
rtl/mwo_dp.sv
rtl/mecanum_wheel_odometry.sv
rtl/mwo_checker.sv
sim/mecanum_wheel_odometry_tb.sv
